// File: design/lsm_pkg.sv
// Shared types and constants for the line substring matcher.
// Used by lsm_front, lsm_queue, lsm_back and line_substring_matcher; no dependencies.
package lsm_pkg;

	// input request codes
	localparam logic [1:0] REQ_LOAD = 2'd0;
	localparam logic [1:0] REQ_DATA = 2'd1;
	localparam logic [1:0] REQ_EOF  = 2'd2;

	// classified operations carried through the queue
	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_BYTE = 2'd1;
	localparam logic [1:0] OP_EOL  = 2'd2;
	localparam logic [1:0] OP_EOF  = 2'd3;

	localparam logic [7:0]  CHAR_CR      = 8'h0D;
	localparam logic [7:0]  CHAR_LF      = 8'h0A;
	localparam logic [7:0]  LEN_OUT_MAX  = 8'd255;
	localparam logic [31:0] LINE_NUM_MAX = 32'hFFFF_FFFF;

	// configuration port
	localparam int         ADDR_W          = 3;
	localparam logic [0:0] REG_PATTERN_LEN = 1'b0;

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data;
		logic [6:0] index;
	} q_item_t;

endpackage

// File: design/lsm_front.sv
// Front end: accepts input items, drops those with no effect and classifies the rest.
// Depends on lsm_pkg.
module lsm_front #(
	parameter int PATTERN_MAX = 127
) (
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       req_type,
	input  logic [7:0]       byte_value,
	input  logic [6:0]       pattern_index,
	input  logic             q_full,
	output logic             push,
	output lsm_pkg::q_item_t push_item
);
	import lsm_pkg::*;

	localparam logic [7:0] PMAX8 = 8'(PATTERN_MAX);

	logic keep;

	always_comb begin
		keep            = 1'b0;
		push_item.op    = OP_LOAD;
		push_item.data  = byte_value;
		push_item.index = pattern_index;
		case (req_type)
			REQ_LOAD: begin
				keep         = ({1'b0, pattern_index} < PMAX8);
				push_item.op = OP_LOAD;
			end
			REQ_DATA: begin
				// carriage returns vanish here
				keep         = (byte_value != CHAR_CR);
				push_item.op = (byte_value == CHAR_LF) ? OP_EOL : OP_BYTE;
			end
			REQ_EOF: begin
				keep         = 1'b1;
				push_item.op = OP_EOF;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign in_stall = q_full;
	assign push     = in_valid && !q_full && keep;

endmodule

// File: design/lsm_queue.sv
// Short FIFO of classified items between the front and back ends.
// Depends on lsm_pkg.
module lsm_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  lsm_pkg::q_item_t push_item,
	output logic             full,
	output logic             head_valid,
	output lsm_pkg::q_item_t head_item,
	input  logic             pop
);
	import lsm_pkg::*;

	q_item_t        items_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;

	assign full       = (count_q == (QAW+1)'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = items_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			items_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: design/lsm_back.sv
// Back end: pattern store, shift-and match cells, line bookkeeping and result register.
// Depends on lsm_pkg.
module lsm_back #(
	parameter int PATTERN_MAX = 127,
	parameter int LINE_MAX    = 255
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  lsm_pkg::q_item_t head_item,
	output logic             pop,
	input  logic [6:0]       pattern_length,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [31:0]      line_number,
	output logic [7:0]       line_length
);
	import lsm_pkg::*;

	localparam int         CW    = $clog2(LINE_MAX + 1);
	localparam int         LW    = (CW > 8) ? CW : 8;
	localparam logic [7:0] PMAX8 = 8'(PATTERN_MAX);

	logic [7:0]             pat_q [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] pm_q;
	logic                   match_q;
	logic                   zero_q;
	logic [CW-1:0]          count_q;
	logic [31:0]            line_q;
	logic                   out_valid_q;
	logic [31:0]            num_q;
	logic [7:0]             len_q;

	logic [7:0]             used;
	logic [PATTERN_MAX-1:0] pm_new;
	logic                   hit;
	logic                   go;
	logic                   room;
	logic                   line_hit;
	logic                   emit;
	logic [LW-1:0]          cnt_ext;
	logic [7:0]             len_out;

	assign used = ({1'b0, pattern_length} > PMAX8) ? PMAX8 : {1'b0, pattern_length};

	// one shift-and step: each cell extends the prefix held by its neighbour
	always_comb begin
		hit = 1'b0;
		for (int j = 0; j < PATTERN_MAX; j++) begin
			pm_new[j] = (8'(j) < used) && ((j == 0) ? 1'b1 : pm_q[(j == 0) ? 0 : j-1])
				&& (pat_q[j] == head_item.data);
			hit = hit || (pm_new[j] && (used != 8'd0) && (8'(j) == used - 8'd1));
		end
	end

	assign go       = head_valid && (!out_valid_q || !out_stall);
	assign pop      = go;
	assign room     = (count_q < CW'(LINE_MAX));
	assign line_hit = (used == 8'd0) || match_q;
	assign emit     = go && line_hit && ((head_item.op == OP_EOL) ||
		((head_item.op == OP_EOF) && (count_q != '0)));
	assign cnt_ext  = LW'(count_q);
	assign len_out  = (cnt_ext > LW'(LEN_OUT_MAX)) ? LEN_OUT_MAX : cnt_ext[7:0];

	for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_pat
		always_ff @(posedge clk) begin
			if (go && (head_item.op == OP_LOAD) && ({1'b0, head_item.index} == 8'(g))) begin
				pat_q[g] <= head_item.data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pm_q        <= '0;
			match_q     <= 1'b0;
			zero_q      <= 1'b0;
			count_q     <= '0;
			line_q      <= 32'd1;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (go) begin
				case (head_item.op)
					OP_BYTE: begin
						if (room) begin
							count_q <= count_q + 1'b1;
							if (head_item.data == 8'd0) begin
								zero_q <= 1'b1;
							end else if (!zero_q) begin
								pm_q <= pm_new;
								if (hit) begin
									match_q <= 1'b1;
								end
							end
						end
					end
					OP_EOL: begin
						pm_q    <= '0;
						match_q <= 1'b0;
						zero_q  <= 1'b0;
						count_q <= '0;
						if (line_q != LINE_NUM_MAX) begin
							line_q <= line_q + 32'd1;
						end
					end
					OP_EOF: begin
						pm_q    <= '0;
						match_q <= 1'b0;
						zero_q  <= 1'b0;
						count_q <= '0;
						line_q  <= 32'd1;
					end
					default: begin
						pm_q <= pm_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			num_q <= line_q;
			len_q <= len_out;
		end
	end

	assign out_valid   = out_valid_q;
	assign line_number = num_q;
	assign line_length = len_q;

endmodule

// File: design/line_substring_matcher.sv
// Top level of the line substring matcher: configuration register and front/queue/back wiring.
// Depends on lsm_pkg, lsm_front, lsm_queue and lsm_back.
//
// The block reads a text stream one byte per item and reports every line that
// contains a fixed pattern. Load the pattern with load items (req_type 0, one
// byte per pattern_index) and set pattern_length through the configuration
// port before sending text; a length of zero matches every line. Data items
// (req_type 1) carry text: a newline ends a line, carriage returns are dropped,
// only the first LINE_MAX bytes of a line are stored, and matching stops at the
// first zero byte. An end-of-file item (req_type 2) flushes a non-empty partial
// line and restarts numbering at 1. Each matching line yields one result item
// with its line number (saturating at the top of 32 bits) and stored length
// (saturating at 255). The front end classifies each input item and pushes
// it into a four-entry queue, and the back end updates all shift-and match
// cells for a text byte in a single step, so items stream back to back while
// the queue has room. A result is registered in the cycle after its newline
// or end-of-file item leaves the queue; the back end only pauses while a
// finished result waits on out_stall.
module line_substring_matcher #(
	parameter int PATTERN_MAX = 127,
	parameter int LINE_MAX    = 255
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [lsm_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	// input items
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 req_type,
	input  logic [7:0]                 byte_value,
	input  logic [6:0]                 pattern_index,
	// result items
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [31:0]                line_number,
	output logic [7:0]                 line_length
);
	import lsm_pkg::*;

	logic [6:0] pattern_length_q;
	logic       cfg_wr;
	logic       sel_len;

	logic    push;
	q_item_t push_item;
	logic    q_full;
	logic    head_valid;
	q_item_t head_item;
	logic    pop;

	// Word address sits in the top bit; only the first word holds a register.
	assign sel_len = (paddr[ADDR_W-1] == REG_PATTERN_LEN);
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign prdata  = sel_len ? {25'd0, pattern_length_q} : 32'd0;

	// Hold the pattern length; the user must write it only while the block is idle (not enforced here).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= 7'd0;
		end else if (cfg_wr && sel_len) begin
			pattern_length_q <= pwdata[6:0];
		end
	end

	// Classify each item and drop those that change nothing downstream.
	lsm_front #(
		.PATTERN_MAX(PATTERN_MAX)
	) u_front (
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.byte_value   (byte_value),
		.pattern_index(pattern_index),
		.q_full       (q_full),
		.push         (push),
		.push_item    (push_item)
	);

	// Decouple the input side from result back-pressure.
	lsm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.head_valid(head_valid),
		.head_item (head_item),
		.pop       (pop)
	);

	// Advance the match cells and line state, and register results.
	lsm_back #(
		.PATTERN_MAX(PATTERN_MAX),
		.LINE_MAX   (LINE_MAX)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_item     (head_item),
		.pop           (pop),
		.pattern_length(pattern_length_q),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.line_number   (line_number),
		.line_length   (line_length)
	);

endmodule
